@@ hw/rtl/tgbc_pkg.sv @@
package tgbc_pkg;

  // Default sizes for the top level parameters
  localparam int DEF_MAX_COLUMNS   = 64;
  localparam int DEF_MAX_ROWS      = 64;
  localparam int DEF_MAX_CELL_SIZE = 16;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Nonnegative pixel edges carried to the back end
  localparam int EDGE_W = 11;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 2'd3;

  // Opcodes of a request
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_BOX   = 2'd2;

  // Command kinds after classification
  localparam logic [1:0] K_FAIL  = 2'd0;
  localparam logic [1:0] K_WRITE = 2'd1;
  localparam logic [1:0] K_READ  = 2'd2;
  localparam logic [1:0] K_BOX   = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [7:0]  cell_col;
    logic signed [7:0]  cell_row;
    logic               tile_blocked;
    logic               image_fits;
    logic signed [11:0] box_left;
    logic signed [11:0] box_top;
    logic signed [11:0] box_right;
    logic signed [11:0] box_bottom;
  } in_item_t;

  typedef struct packed {
    logic ok;
    logic blocked_out;
  } out_item_t;

  // Saturated configuration, as seen by front and back
  typedef struct packed {
    logic [6:0] map_columns;
    logic [6:0] map_rows;
    logic [4:0] cell_width;
    logic [4:0] cell_height;
  } cfg_t;

  // Queue entry
  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        col;
    logic [7:0]        row;
    logic              blk;
    logic [EDGE_W-1:0] left;
    logic [EDGE_W-1:0] top;
    logic [EDGE_W-1:0] right;
    logic [EDGE_W-1:0] bottom;
  } cmd_t;

  // Saturate a count register to 1..hi
  function automatic logic [6:0] clamp_count(input logic [6:0] v, input int hi);
    logic [6:0] r;
    if (v == 7'd0) begin
      r = 7'd1;
    end else if (int'(v) > hi) begin
      r = 7'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Saturate a cell size register to 1..hi
  function automatic logic [4:0] clamp_size(input logic [4:0] v, input int hi);
    logic [4:0] r;
    if (v == 5'd0) begin
      r = 5'd1;
    end else if (int'(v) > hi) begin
      r = 5'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/tgbc_ram.sv @@
module tgbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/tgbc_queue.sv @@
module tgbc_queue
  import tgbc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int PTR_W = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == CNT_W'(0));
  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  // Payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/tgbc_div.sv @@
module tgbc_div
  import tgbc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [EDGE_W-1:0] dividend,
  input  logic [4:0]        divisor,
  output logic              done,
  output logic [EDGE_W-1:0] quotient
);

  localparam int CNT_W = $clog2(EDGE_W + 1);

  logic [4:0]       rem;
  logic [CNT_W-1:0] cnt;
  logic             active;
  logic [5:0]       trial;
  logic             take;

  // Restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem, quotient[EDGE_W-1]};
  assign take  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
    end else if (active) begin
      rem      <= take ? 5'(trial - {1'b0, divisor}) : trial[4:0];
      quotient <= {quotient[EDGE_W-2:0], take};
    end
  end

  // Bit counter and completion strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNT_W'(EDGE_W);
      end else if (active) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hw/rtl/tgbc_front.sv @@
module tgbc_front
  import tgbc_pkg::*;
(
  input  logic     start,
  input  logic     hold,
  input  in_item_t request,
  input  cfg_t     cfg,
  output logic     push,
  output cmd_t     cmd
);

  logic        cell_in;
  logic [11:0] pix_w;
  logic [11:0] pix_h;
  logic        box_ok;

  assign push = start && !hold;

  // Cell inside the map in use
  assign cell_in = !request.cell_col[7] && !request.cell_row[7] &&
                   (request.cell_col[6:0] < cfg.map_columns) &&
                   (request.cell_row[6:0] < cfg.map_rows);

  // Pixel area of the map
  assign pix_w = {5'd0, cfg.map_columns} * {7'd0, cfg.cell_width};
  assign pix_h = {5'd0, cfg.map_rows} * {7'd0, cfg.cell_height};

  // Box ordered, nonnegative and inside the pixel area
  assign box_ok = ($signed(request.box_right) >= $signed(request.box_left)) &&
                  ($signed(request.box_bottom) >= $signed(request.box_top)) &&
                  !request.box_left[11] && !request.box_top[11] &&
                  (request.box_right[11:0] < pix_w) &&
                  (request.box_bottom[11:0] < pix_h);

  // Classify the request
  always_comb begin
    cmd.col    = request.cell_col[7:0];
    cmd.row    = request.cell_row[7:0];
    cmd.blk    = request.tile_blocked;
    cmd.left   = request.box_left[EDGE_W-1:0];
    cmd.top    = request.box_top[EDGE_W-1:0];
    cmd.right  = request.box_right[EDGE_W-1:0];
    cmd.bottom = request.box_bottom[EDGE_W-1:0];
    case (request.opcode)
      OP_WRITE: cmd.kind = (cell_in && request.image_fits) ? K_WRITE : K_FAIL;
      OP_READ:  cmd.kind = cell_in ? K_READ : K_FAIL;
      OP_BOX:   cmd.kind = box_ok ? K_BOX : K_FAIL;
      default:  cmd.kind = K_FAIL;
    endcase
  end

endmodule

@@ hw/rtl/tgbc_back.sv @@
module tgbc_back
  import tgbc_pkg::*;
#(
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  cmd_t      head,
  input  logic      empty,
  output logic      pop,
  output logic      clearing,
  output logic      done,
  output out_item_t result
);

  localparam int CIDX_W = MAX_COLUMNS > 1 ? $clog2(MAX_COLUMNS) : 1;
  localparam int RIDX_W = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_ACC     = 3'd2;
  localparam logic [2:0] S_DIVGO   = 3'd3;
  localparam logic [2:0] S_DIVWAIT = 3'd4;
  localparam logic [2:0] S_SCAN    = 3'd5;
  localparam logic [2:0] S_CHK     = 3'd6;

  logic [2:0]             state;
  logic [RIDX_W-1:0]      clr_row;
  cmd_t                   cmd;
  logic [1:0]             div_sel;
  logic [CIDX_W-1:0]      x0;
  logic [CIDX_W-1:0]      x1;
  logic [RIDX_W-1:0]      y0;
  logic [RIDX_W-1:0]      y1;
  logic [RIDX_W-1:0]      scan_row;

  logic                   we;
  logic [RIDX_W-1:0]      waddr;
  logic [MAX_COLUMNS-1:0] wdata;
  logic [RIDX_W-1:0]      raddr;
  logic [MAX_COLUMNS-1:0] rdata;
  logic [CIDX_W-1:0]      col_idx;
  logic [RIDX_W-1:0]      row_idx;
  logic [MAX_COLUMNS-1:0] mask;

  logic                   div_start;
  logic [EDGE_W-1:0]      div_dividend;
  logic [4:0]             div_divisor;
  logic                   div_done;
  logic [EDGE_W-1:0]      div_quo;

  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && !empty;
  assign col_idx  = cmd.col[CIDX_W-1:0];
  assign row_idx  = cmd.row[RIDX_W-1:0];

  // Grid memory port control
  always_comb begin
    we    = clearing || ((state == S_ACC) && (cmd.kind == K_WRITE));
    waddr = clearing ? clr_row : row_idx;
    wdata = rdata;
    wdata[col_idx] = cmd.blk;
    if (clearing) begin
      wdata = '0;
    end
    raddr = (state == S_IDLE) ? head.row[RIDX_W-1:0] : scan_row;
  end

  tgbc_ram #(
    .WIDTH (MAX_COLUMNS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Edge to divide: left, right by width, then top, bottom by height
  always_comb begin
    div_start   = (state == S_DIVGO);
    div_divisor = div_sel[1] ? cfg.cell_height : cfg.cell_width;
    case (div_sel)
      2'd0:    div_dividend = cmd.left;
      2'd1:    div_dividend = cmd.right;
      2'd2:    div_dividend = cmd.top;
      default: div_dividend = cmd.bottom;
    endcase
  end

  tgbc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Columns x0..x1 of the row word
  assign mask = ({MAX_COLUMNS{1'b1}} << x0) &
                ({MAX_COLUMNS{1'b1}} >> (CIDX_W'(MAX_COLUMNS - 1) - x1));

  // Command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_row <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_row <= clr_row + RIDX_W'(1);
          if (clr_row == RIDX_W'(MAX_ROWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!empty) begin
            case (head.kind)
              K_WRITE, K_READ: state <= S_ACC;
              K_BOX: begin
                div_sel <= 2'd0;
                state   <= S_DIVGO;
              end
              default: begin
                done               <= 1'b1;
                result.ok          <= 1'b0;
                result.blocked_out <= 1'b0;
              end
            endcase
          end
        end
        S_ACC: begin
          done               <= 1'b1;
          result.ok          <= 1'b1;
          result.blocked_out <= (cmd.kind == K_READ) && rdata[col_idx];
          state              <= S_IDLE;
        end
        S_DIVGO: state <= S_DIVWAIT;
        S_DIVWAIT: begin
          if (div_done) begin
            case (div_sel)
              2'd0:    x0 <= div_quo[CIDX_W-1:0];
              2'd1:    x1 <= div_quo[CIDX_W-1:0];
              2'd2:    y0 <= div_quo[RIDX_W-1:0];
              default: y1 <= div_quo[RIDX_W-1:0];
            endcase
            if (div_sel == 2'd3) begin
              scan_row <= y0;
              state    <= S_SCAN;
            end else begin
              div_sel <= div_sel + 2'd1;
              state   <= S_DIVGO;
            end
          end
        end
        S_SCAN: state <= S_CHK;
        S_CHK: begin
          if (|(rdata & mask)) begin
            done               <= 1'b1;
            result.ok          <= 1'b0;
            result.blocked_out <= 1'b0;
            state              <= S_IDLE;
          end else if (scan_row == y1) begin
            done               <= 1'b1;
            result.ok          <= 1'b1;
            result.blocked_out <= 1'b0;
            state              <= S_IDLE;
          end else begin
            scan_row <= scan_row + RIDX_W'(1);
            state    <= S_SCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Latch the command taken from the queue
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head;
    end
  end

endmodule

@@ hw/rtl/tile_grid_box_clearance.sv @@
// Tile grid with box clearance check. A request is taken when start is high and
// busy is low; each request yields one result, shown on result for exactly one
// cycle with done high, and the receiver cannot stall it. After reset the grid
// is cleared one row per cycle, with busy high. Requests are classified on
// entry and queued (two deep); the back end then answers a rejected request
// straight from its idle state, and a write or a read by way of its access state.
// An accepted box needs 4 serial divisions of its edges on the shared
// bit-serial divider, then a check of each covered tile row in turn, through
// the single read port of the grid memory. Configuration may be written only
// while no request is outstanding.
module tile_grid_box_clearance
  import tgbc_pkg::*;
#(
  parameter int MAX_COLUMNS   = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS      = DEF_MAX_ROWS,
  parameter int MAX_CELL_SIZE = DEF_MAX_CELL_SIZE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              request,
  output logic                  done,
  output out_item_t             result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [6:0] map_columns;
  logic [6:0] map_rows;
  logic [4:0] cell_width;
  logic [4:0] cell_height;
  cfg_t       cfg;
  logic       push;
  cmd_t       push_cmd;
  cmd_t       head;
  logic       q_empty;
  logic       q_full;
  logic       pop;
  logic       clearing;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      map_columns <= 7'd64;
      map_rows    <= 7'd64;
      cell_width  <= 5'd8;
      cell_height <= 5'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAP_COLUMNS: map_columns <= cfg_data[6:0];
        REG_MAP_ROWS:    map_rows    <= cfg_data[6:0];
        REG_CELL_WIDTH:  cell_width  <= cfg_data[4:0];
        REG_CELL_HEIGHT: cell_height <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Saturated view of the registers
  assign cfg.map_columns = clamp_count(map_columns, MAX_COLUMNS);
  assign cfg.map_rows    = clamp_count(map_rows, MAX_ROWS);
  assign cfg.cell_width  = clamp_size(cell_width, MAX_CELL_SIZE);
  assign cfg.cell_height = clamp_size(cell_height, MAX_CELL_SIZE);

  assign busy = clearing || q_full;

  tgbc_front u_front (
    .start   (start),
    .hold    (busy),
    .request (request),
    .cfg     (cfg),
    .push    (push),
    .cmd     (push_cmd)
  );

  tgbc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  tgbc_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .clearing (clearing),
    .done     (done),
    .result   (result)
  );

endmodule

@@ hw/rtl/tgbc_checker.sv @@
module tgbc_checker
  import tgbc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input out_item_t             result,
  input logic                  cfg_we
);

  logic [2:0] pending;
  logic       accept;

  assign accept = start && !busy;

  // Requests taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {2'd0, accept} - {2'd0, done};
    end
  end

  // Grid clearing keeps requests out right after reset
  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  // No result in the cycle after reset
  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // Every result answers an earlier request
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> (pending != 3'd0))
    else $error("result without outstanding request");

  // A blocked bit is only reported for a successful read
  a_blocked_needs_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result.blocked_out) |-> result.ok)
    else $error("blocked_out set without ok");

  // Configuration writes only while nothing is outstanding
  a_cfg_when_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> (pending == 3'd0))
    else $error("configuration written with request outstanding");

endmodule

bind tile_grid_box_clearance tgbc_checker u_tgbc_checker (.*);

@@ sim/tile_grid_checker.sv @@
module tile_grid_checker
  import tgbc_pkg::*;
#(
  parameter int MAX_COLUMNS   = DEF_MAX_COLUMNS,
  parameter int MAX_ROWS      = DEF_MAX_ROWS,
  parameter int MAX_CELL_SIZE = DEF_MAX_CELL_SIZE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  in_item_t              request,
  input  logic                  done,
  input  out_item_t             result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  // Shadow grid, tile (col,row) at row * MAX_COLUMNS + col
  bit         blocked_map [MAX_ROWS*MAX_COLUMNS];
  logic [6:0] reg_cols;
  logic [6:0] reg_rows;
  logic [4:0] reg_width;
  logic [4:0] reg_height;
  out_item_t  answers_due [$];
  out_item_t  want;

  initial mismatches = 0;

  // Register value as used by the datapath: 0 reads as 1, top end saturates
  function automatic int saturate(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit tile_inside(int col, int row);
    return col >= 0 && row >= 0 &&
           col < saturate(reg_cols, MAX_COLUMNS) &&
           row < saturate(reg_rows, MAX_ROWS);
  endfunction

  // Box placement: edges must be ordered and inside the pixel area,
  // then every covered tile must be clear
  function automatic bit box_clear(int l, int t, int r, int b);
    int tw;
    int th;
    tw = saturate(reg_width, MAX_CELL_SIZE);
    th = saturate(reg_height, MAX_CELL_SIZE);
    if (r < l || b < t) return 1'b0;
    if (l < 0 || t < 0) return 1'b0;
    if (r >= saturate(reg_cols, MAX_COLUMNS) * tw) return 1'b0;
    if (b >= saturate(reg_rows, MAX_ROWS) * th) return 1'b0;
    for (int y = t / th; y <= b / th; y++) begin
      for (int x = l / tw; x <= r / tw; x++) begin
        if (blocked_map[y*MAX_COLUMNS+x]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Expected answer to one request; a write updates the shadow grid
  function automatic out_item_t apply_request(in_item_t q);
    out_item_t a;
    int col;
    int row;
    a   = '0;
    col = $signed(q.cell_col);
    row = $signed(q.cell_row);
    case (q.opcode)
      OP_WRITE: begin
        if (tile_inside(col, row) && q.image_fits) begin
          blocked_map[row*MAX_COLUMNS+col] = q.tile_blocked;
          a.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (tile_inside(col, row)) begin
          a.ok          = 1'b1;
          a.blocked_out = blocked_map[row*MAX_COLUMNS+col];
        end
      end
      OP_BOX: begin
        a.ok = box_clear($signed(q.box_left), $signed(q.box_top),
                         $signed(q.box_right), $signed(q.box_bottom));
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
  endtask

  // Track config writes, compare results in order, queue new requests
  always @(posedge clk) begin
    if (rst) begin
      foreach (blocked_map[i]) blocked_map[i] = 1'b0;
      reg_cols   = 7'd64;
      reg_rows   = 7'd64;
      reg_width  = 5'd8;
      reg_height = 5'd8;
      answers_due.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAP_COLUMNS: reg_cols   = cfg_data;
          REG_MAP_ROWS:    reg_rows   = cfg_data;
          REG_CELL_WIDTH:  reg_width  = cfg_data[4:0];
          REG_CELL_HEIGHT: reg_height = cfg_data[4:0];
          default: ;
        endcase
      end
      if (done) begin
        if (answers_due.size() == 0) begin
          note_failure($sformatf("result ok=%b blocked=%b with no request outstanding",
                                 result.ok, result.blocked_out));
        end else begin
          want = answers_due.pop_front();
          if (result.ok !== want.ok || result.blocked_out !== want.blocked_out) begin
            note_failure($sformatf("mismatch: expected ok=%b blocked=%b, got ok=%b blocked=%b",
                                   want.ok, want.blocked_out, result.ok, result.blocked_out));
          end
        end
      end
      if (start && !busy) answers_due.push_back(apply_request(request));
      outstanding <= answers_due.size();
    end
  end

endmodule

@@ sim/tile_grid_box_clearance_tb.sv @@
module tile_grid_box_clearance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tgbc_pkg::*;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         TAIL_CYCLES    = 200;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  in_item_t              request;
  logic                  done;
  out_item_t             result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    outstanding;
  int                    quiet_cycles;

  // Current map geometry, only used to aim the random requests
  int tiles_x = 64;
  int tiles_y = 64;
  int tw      = 8;
  int th      = 8;
  bit idle_on = 1'b1;

  always #4 clk = ~clk;

  tile_grid_box_clearance dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tile_grid_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .done        (done),
    .result      (result),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Watchdog: cycles with neither a request nor a result taken
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  function automatic in_item_t mk(logic [1:0] op, int col, int row, bit blk, bit fits,
                                  int l, int t, int r, int b);
    in_item_t q;
    q.opcode       = op;
    q.cell_col     = 8'(col);
    q.cell_row     = 8'(row);
    q.tile_blocked = blk;
    q.image_fits   = fits;
    q.box_left     = 12'(l);
    q.box_top      = 12'(t);
    q.box_right    = 12'(r);
    q.box_bottom   = 12'(b);
    return q;
  endfunction

  // Mostly well-formed tile and box requests near the origin, some noise
  function automatic in_item_t random_request();
    in_item_t q;
    int px_w;
    int px_h;
    int hot_x;
    int hot_y;
    int l;
    int t;
    int span;
    int pick;
    px_w  = tiles_x * tw;
    px_h  = tiles_y * th;
    hot_x = (tiles_x < 6) ? tiles_x : 6;
    hot_y = (tiles_y < 6) ? tiles_y : 6;
    q.opcode       = 2'($urandom);
    q.cell_col     = 8'($urandom);
    q.cell_row     = 8'($urandom);
    q.tile_blocked = 1'($urandom);
    q.image_fits   = 1'($urandom);
    q.box_left     = 12'($urandom);
    q.box_top      = 12'($urandom);
    q.box_right    = 12'($urandom);
    q.box_bottom   = 12'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      q.opcode = (pick < 30) ? OP_WRITE : OP_READ;
      if ($urandom_range(0, 7) != 0) begin
        q.cell_col     = 8'($urandom_range(0, ($urandom_range(0, 1) ? hot_x : tiles_x) - 1));
        q.cell_row     = 8'($urandom_range(0, ($urandom_range(0, 1) ? hot_y : tiles_y) - 1));
        q.tile_blocked = ($urandom_range(0, 9) < 3);
        q.image_fits   = ($urandom_range(0, 9) != 0);
      end
    end else if (pick < 95) begin
      q.opcode = OP_BOX;
      if ($urandom_range(0, 7) != 0) begin
        if ($urandom_range(0, 1)) begin
          l = $urandom_range(0, hot_x * tw - 1);
          t = $urandom_range(0, hot_y * th - 1);
        end else begin
          l = $urandom_range(0, px_w - 1);
          t = $urandom_range(0, px_h - 1);
        end
        q.box_left   = 12'(l);
        q.box_top    = 12'(t);
        span         = l + $urandom_range(0, 3 * tw);
        q.box_right  = 12'((span < px_w) ? span : px_w - 1);
        span         = t + $urandom_range(0, 2 * th);
        q.box_bottom = 12'((span < px_h) ? span : px_h - 1);
        case ($urandom_range(0, 31))
          0: begin
            q.box_left   = '0;
            q.box_top    = '0;
            q.box_right  = 12'(px_w - 1);
            q.box_bottom = 12'(px_h - 1);
          end
          1: q.box_right  = 12'(px_w);
          2: q.box_bottom = 12'(px_h);
          3: q.box_right  = 12'(l - 1);
          4: q.box_bottom = 12'(t - 1);
          default: ;
        endcase
      end
    end else begin
      q.opcode = OP_UNUSED;
    end
    return q;
  endfunction

  // One request; start stays high into the next one unless the sender idles
  task automatic issue(input in_item_t q);
    start   <= 1'b1;
    request <= q;
    do @(posedge clk); while (busy);
    if (idle_on && $urandom_range(0, 99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 80) : $urandom_range(1, 6))
        @(posedge clk);
    end
  endtask

  task automatic run_random(input int count);
    repeat (count) issue(random_request());
  endtask

  // Drain all outstanding requests, then write the four registers back to back
  task automatic load_map(input logic [6:0] cols, input logic [6:0] rows,
                          input logic [6:0] w, input logic [6:0] h);
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MAP_COLUMNS;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_index <= REG_MAP_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_index <= REG_CELL_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_CELL_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we  <= 1'b0;
    tiles_x = clamp_count(cols, DEF_MAX_COLUMNS);
    tiles_y = clamp_count(rows, DEF_MAX_ROWS);
    tw      = clamp_size(w[4:0], DEF_MAX_CELL_SIZE);
    th      = clamp_size(h[4:0], DEF_MAX_CELL_SIZE);
  endtask

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    request   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_MAP_COLUMNS;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: 64x64 map of 8x8 tiles, pixel area 512x512
    issue(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_WRITE, 0, 0, 1, 1, 0, 0, 0, 0));
    issue(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_WRITE, 63, 63, 1, 1, 0, 0, 0, 0));
    issue(mk(OP_READ, 63, 63, 0, 0, 0, 0, 0, 0));
    // tile outside the map, either side
    issue(mk(OP_WRITE, 64, 0, 1, 1, 0, 0, 0, 0));
    issue(mk(OP_WRITE, 0, 64, 1, 1, 0, 0, 0, 0));
    issue(mk(OP_WRITE, -1, 0, 1, 1, 0, 0, 0, 0));
    issue(mk(OP_WRITE, -128, 127, 1, 1, 0, 0, 0, 0));
    issue(mk(OP_READ, 127, -128, 0, 0, 0, 0, 0, 0));
    // image does not fit: write rejected, grid unchanged
    issue(mk(OP_WRITE, 5, 5, 1, 0, 0, 0, 0, 0));
    issue(mk(OP_READ, 5, 5, 0, 0, 0, 0, 0, 0));
    // boxes: clear, on a blocked tile, single column and single row of pixels
    issue(mk(OP_BOX, 0, 0, 0, 0, 8, 8, 15, 15));
    issue(mk(OP_BOX, 0, 0, 0, 0, 0, 0, 0, 0));
    issue(mk(OP_BOX, 0, 0, 0, 0, 100, 16, 100, 200));
    issue(mk(OP_BOX, 0, 0, 0, 0, 16, 300, 400, 300));
    // inverted edges, negative edge, right edge on and past the area
    issue(mk(OP_BOX, 0, 0, 0, 0, 20, 20, 19, 30));
    issue(mk(OP_BOX, 0, 0, 0, 0, 20, 30, 40, 29));
    issue(mk(OP_BOX, 0, 0, 0, 0, -1, 8, 8, 8));
    issue(mk(OP_BOX, 0, 0, 0, 0, 504, 0, 511, 7));
    issue(mk(OP_BOX, 0, 0, 0, 0, 504, 0, 512, 7));
    issue(mk(OP_BOX, 0, 0, 0, 0, 504, 504, 511, 511));
    issue(mk(OP_BOX, 0, 0, 0, 0, -2048, -2048, 2047, 2047));
    // unused opcode with every field set
    issue(mk(OP_UNUSED, -1, -1, 1, 1, -1, -1, -1, -1));
    // clear the origin tile, then a near-full scan still hits (63,63)
    issue(mk(OP_WRITE, 0, 0, 0, 1, 0, 0, 0, 0));
    issue(mk(OP_BOX, 0, 0, 0, 0, 0, 0, 511, 510));

    run_random(150);
    load_map(7'd1, 7'd1, 7'd1, 7'd1);
    run_random(100);
    // largest map with no sender idling
    idle_on = 1'b0;
    load_map(7'd64, 7'd64, 7'd16, 7'd16);
    run_random(150);
    idle_on = 1'b1;
    // zero and out-of-range register values saturate
    load_map(7'd0, 7'd127, 7'd0, 7'h1f);
    run_random(120);
    load_map(7'd127, 7'd0, 7'h65, 7'h7f);
    run_random(120);
    load_map(7'd5, 7'd3, 7'd3, 7'd7);
    run_random(150);
    load_map(7'd37, 7'd50, 7'd16, 7'd1);
    run_random(150);
    load_map(7'd64, 7'd64, 7'd8, 7'd8);
    run_random(200);

    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (outstanding != 0) $display("%0d results never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ tile_grid_box_clearance.f @@
hw/rtl/tgbc_pkg.sv
hw/rtl/tgbc_ram.sv
hw/rtl/tgbc_queue.sv
hw/rtl/tgbc_div.sv
hw/rtl/tgbc_front.sv
hw/rtl/tgbc_back.sv
hw/rtl/tile_grid_box_clearance.sv
hw/rtl/tgbc_checker.sv
sim/tile_grid_checker.sv
sim/tile_grid_box_clearance_tb.sv
